### hdl/setq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_pkg
// Types, constants and helpers shared by the sorted expiry timer queue.
// ----------------------------------------------------------------------------
package setq_pkg;

	localparam int ID_W      = 4;
	localparam int TIME_W    = 32;
	localparam int NUM_IDS   = 2 ** ID_W;
	localparam int MAX_OUT   = 16;
	localparam int CNT_W     = $clog2(MAX_OUT + 1);

	typedef enum logic [1:0] {
		OP_START_REL = 2'd0,
		OP_START_ABS = 2'd1,
		OP_STOP      = 2'd2,
		OP_TICK      = 2'd3
	} op_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_BUSY = 1'b1;

	// one queue entry held by a cell
	typedef struct packed {
		logic              v;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] exp;
	} entry_t;

	// walking token: an insert carries the entry being placed (later the
	// displaced one), a delete carries the id to find and then pulls left
	typedef struct packed {
		logic              v;
		logic              del;
		logic              found;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] exp;
	} tok_t;

	// wrap-safe order: a is before b when (a - b) is negative
	function automatic logic is_before(input logic [TIME_W-1:0] a,
	                                   input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

endpackage

### hdl/setq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_cell
// One slot of the sorted chain: holds an entry, passes the walking token on.
// ----------------------------------------------------------------------------
module setq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop,
	input  setq_pkg::tok_t  tok_in,
	input  setq_pkg::entry_t right,
	output setq_pkg::tok_t  tok_out,
	output setq_pkg::entry_t res
);

	setq_pkg::entry_t res_q, res_d;
	setq_pkg::tok_t   tok_q, tok_d;
	logic             take;
	logic             pull;

	always_comb begin
		res_d = res_q;
		tok_d = tok_in;
		tok_d.v = 1'b0;
		take = tok_in.found || !res_q.v || setq_pkg::is_before(tok_in.exp, res_q.exp);
		pull = tok_in.found || (res_q.v && (res_q.id == tok_in.id));
		if (pop) begin
			res_d = right;
		end else if (tok_in.v) begin
			if (!tok_in.del) begin
				if (take) begin
					// drop the carried entry here, carry the old one onward
					res_d.v   = 1'b1;
					res_d.id  = tok_in.id;
					res_d.exp = tok_in.exp;
					tok_d.v     = res_q.v;
					tok_d.found = 1'b1;
					tok_d.id    = res_q.id;
					tok_d.exp   = res_q.exp;
				end else begin
					tok_d = tok_in;
				end
			end else begin
				if (pull) begin
					res_d = right;
					tok_d.found = 1'b1;
					tok_d.v = right.v;
				end else begin
					tok_d.v = res_q.v;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			tok_q <= '0;
		end else begin
			res_q <= res_d;
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;
	assign res     = res_q;

endmodule

### hdl/sorted_expiry_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_queue
// Timer queue kept sorted by 32-bit expiry in a chain of cells.
// ----------------------------------------------------------------------------
// The queue lives in a row of SLOTS cells, head first. A start or stop
// launches a token that walks the row one cell per clock, inserting the
// timer in place or pulling the tail left over the stopped one; a start or
// stop that walks gives its result beat once the token walk has ended.
// A refused start, a stop of an idle timer or an out-of-range id sends no
// token. A tick gives one beat when nothing is due, else one beat per
// expired timer: the whole row shifts toward the head in one clock per
// expiry beat while the output is not stalled, at most 16 per tick.
// A new item is taken once the previous one is done; its last beat may
// still sit in the output register. Reset is immediate, no clearing pass.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_queue #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  timer_id,
	input  logic [31:0] time_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        expired_valid,
	output logic [3:0]  expired_id,
	output logic        last,
	output logic [31:0] current_time
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

	state_t state_q;

	setq_pkg::entry_t res_ent [SLOTS];
	setq_pkg::tok_t   tok_chain [SLOTS+1];
	logic [SLOTS-1:0] tok_busy;
	setq_pkg::entry_t empty_ent;

	setq_pkg::tok_t   launch_q;
	logic [setq_pkg::NUM_IDS-1:0] active_q;
	logic [31:0]      tick_q;
	logic             status_q;
	logic [setq_pkg::CNT_W-1:0] n_q;
	logic             pop;

	logic             in_acc;
	logic             out_free;
	logic             chain_busy;
	logic             id_ok;
	logic             is_act;
	logic [31:0]      now1;
	logic             due0;
	logic             due1;
	logic             final_beat;
	logic             launch_go;
	logic             beat_go;

	assign empty_ent = '0;
	assign tok_chain[0] = launch_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		setq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.pop    (pop),
			.tok_in (tok_chain[i]),
			.right  ((i == SLOTS - 1) ? empty_ent : res_ent[(i + 1) % SLOTS]),
			.tok_out(tok_chain[i+1]),
			.res    (res_ent[i])
		);
		assign tok_busy[i] = tok_chain[i+1].v;
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_free   = !out_valid || out_ready;
	assign chain_busy = launch_q.v || (|tok_busy);
	assign id_ok      = ({28'd0, timer_id} < 32'(SLOTS));
	assign is_act     = active_q[timer_id];

	// stop of a queued timer or start of an idle one sends a token
	assign launch_go = in_acc && (op != setq_pkg::OP_TICK) && id_ok &&
	                   ((op == setq_pkg::OP_STOP) ? is_act : !is_act);
	assign beat_go   = ((state_q == ST_WALK) && !chain_busy && out_free) ||
	                   ((state_q == ST_SCAN) && out_free);

	// head is due when (now + 1 - expiry) is not negative
	assign now1  = tick_q + 32'd1;
	assign due0  = res_ent[0].v && !setq_pkg::is_before(now1, res_ent[0].exp);
	assign due1  = res_ent[1].v && !setq_pkg::is_before(now1, res_ent[1].exp);
	assign final_beat = !due1 || (n_q == setq_pkg::CNT_W'(setq_pkg::MAX_OUT - 1));
	assign pop   = (state_q == ST_SCAN) && out_free && due0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			launch_q  <= '0;
			active_q  <= '0;
			tick_q    <= '0;
			n_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			launch_q.v <= launch_go;
			out_valid  <= beat_go || (out_valid && !out_ready);
			if (in_acc) begin
				launch_q.del   <= (op == setq_pkg::OP_STOP);
				launch_q.found <= 1'b0;
				launch_q.id    <= timer_id;
				launch_q.exp   <= (op == setq_pkg::OP_START_REL) ? (tick_q + time_value)
				                                                 : time_value;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == setq_pkg::OP_TICK) begin
							tick_q  <= tick_q + 32'd1;
							n_q     <= '0;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_WALK;
							if (launch_go) begin
								active_q[timer_id] <= (op != setq_pkg::OP_STOP);
							end
						end
					end
				end
				ST_WALK: begin
					if (!chain_busy && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (out_free) begin
						if (due0) begin
							active_q[res_ent[0].id] <= 1'b0;
							n_q <= n_q + 1'b1;
							if (final_beat) begin
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= (id_ok && is_act && op != setq_pkg::OP_STOP) ?
			            setq_pkg::STATUS_BUSY : setq_pkg::STATUS_OK;
		end
		if (state_q == ST_WALK && !chain_busy && out_free) begin
			status        <= status_q;
			expired_valid <= 1'b0;
			expired_id    <= '0;
			last          <= 1'b1;
			current_time  <= tick_q;
		end
		if (state_q == ST_SCAN && out_free) begin
			status        <= setq_pkg::STATUS_OK;
			expired_valid <= due0;
			expired_id    <= due0 ? res_ent[0].id : '0;
			last          <= due0 ? final_beat : 1'b1;
			current_time  <= tick_q;
		end
	end

endmodule

### hdl/setq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_checker
// Port-level checks for the sorted expiry timer queue, bound to the top.
// ----------------------------------------------------------------------------
module setq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic        expired_valid,
	input logic [3:0]  expired_id,
	input logic        last,
	input logic [31:0] current_time
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(expired_id) &&
		$stable(current_time) && $stable(last))
		else $error("result beat changed while stalled");

	// an expiry beat never carries a refusal
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired_valid |-> !status)
		else $error("expiry beat with error status");

	// anything but an expiry beat is a lone beat
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !expired_valid |-> last)
		else $error("non-expiry beat not marked last");

	// no new item while a tick still has beats to give
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken in the middle of an expiry burst");

endmodule

bind sorted_expiry_timer_queue setq_checker u_setq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.expired_valid(expired_valid),
	.expired_id   (expired_id),
	.last         (last),
	.current_time (current_time)
);
